### rtl/core/u8u16_pkg.sv
package u8u16_pkg;

  // One result beat: a UTF-16 code unit and its end-of-string mark.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } unit_t;

  // Sequence length codes, counted in continuation bytes.
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // Code point limits used to reject overlong and out-of-range values.
  localparam logic [20:0] MIN_TWO      = 21'h00080;
  localparam logic [20:0] MIN_THREE    = 21'h00800;
  localparam logic [20:0] SURR_LO      = 21'h0D800;
  localparam logic [20:0] SURR_HI      = 21'h0E000;
  localparam logic [20:0] NONCHAR      = 21'h0FFFE;
  localparam logic [20:0] MIN_FOUR     = 21'h10000;
  localparam logic [20:0] MAX_UNICODE  = 21'h110000;

  // Surrogate prefixes (top six bits of the code unit).
  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

endpackage

### rtl/core/utf8_to_utf16_stream_decoder.sv
// UTF-8 to UTF-16 stream decoder. Takes one UTF-8 byte per beat and returns
// UTF-16 code units; a zero byte ends the string with a zero unit marked by
// end_of_string_o and clears any pending sequence. Malformed input (overlong
// forms, surrogates, U+FFFE/U+FFFF, values above U+10FFFF, stray continuation
// bytes, bytes 0xF8..0xFF, broken sequences) produces no output. Throughput is
// one byte per clock: a byte is captured in an input register, decoded
// combinationally and written to a four-entry result queue. A four-byte
// character gives two result beats (high surrogate first) for its four
// input bytes, so an output that is never stalled never holds back the
// input. The input stalls only while the result queue holds more than two
// beats, which happens when the output is stalled.
module utf8_to_utf16_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        end_of_string_o
);

  // Input register.
  logic       ib_valid_q, ib_valid_d;
  logic [7:0] ib_q;
  logic       in_accept;
  logic       fire;

  // Decoder state.
  logic [20:0] pv_q, pv_d;
  logic [1:0]  rem_q, rem_d;
  logic [1:0]  len_q, len_d;

  // Result queue.
  u8u16_pkg::unit_t                 q_mem [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QAW-1:0]        wr_q, rd_q;
  logic [u8u16_pkg::QAW:0]          cnt_q, cnt_d;
  logic                             pop;

  // Decode results.
  logic [1:0]        push_n;
  u8u16_pkg::unit_t  unit0, unit1;
  logic [20:0]       w_next;
  logic [19:0]       v_off;
  logic [1:0]        rem_dec;
  logic              is_cont;

  // The decoder fires when the queue has room for a surrogate pair.
  assign fire       = ib_valid_q && (cnt_q <= (u8u16_pkg::QAW+1)'(u8u16_pkg::QDEPTH - 2));
  assign in_stall_o = ib_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ib_valid_d = in_accept || (ib_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ib_valid_q <= 1'b0;
    end else begin
      ib_valid_q <= ib_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ib_q <= in_byte_i;
    end
  end

  // Continuation bytes shift six bits into the gathered value.
  assign is_cont = (ib_q[7:6] == 2'b10);
  assign w_next  = {pv_q[14:0], ib_q[5:0]};
  assign v_off   = 20'(w_next - u8u16_pkg::MIN_FOUR);
  assign rem_dec = rem_q - 2'd1;

  // Byte decode: next state and up to two result beats.
  always_comb begin
    pv_d   = pv_q;
    rem_d  = rem_q;
    len_d  = len_q;
    push_n = 2'd0;
    unit0  = '{code_unit: 16'h0000, end_of_string: 1'b0};
    unit1  = '{code_unit: 16'h0000, end_of_string: 1'b0};
    if (ib_q == 8'h00) begin
      // End of string: drop anything pending and emit the marked zero.
      pv_d   = '0;
      rem_d  = 2'd0;
      len_d  = u8u16_pkg::SEQ_NONE;
      push_n = 2'd1;
      unit0  = '{code_unit: 16'h0000, end_of_string: 1'b1};
    end else if ((rem_q != 2'd0) && is_cont) begin
      pv_d  = w_next;
      rem_d = rem_dec;
      if (rem_dec == 2'd0) begin
        // Sequence complete: check the value and clear the state.
        pv_d  = '0;
        len_d = u8u16_pkg::SEQ_NONE;
        case (len_q)
          u8u16_pkg::SEQ_TWO: begin
            if (w_next >= u8u16_pkg::MIN_TWO) begin
              push_n          = 2'd1;
              unit0.code_unit = w_next[15:0];
            end
          end
          u8u16_pkg::SEQ_THREE: begin
            if ((w_next >= u8u16_pkg::MIN_THREE) &&
                ((w_next < u8u16_pkg::SURR_LO) || (w_next >= u8u16_pkg::SURR_HI)) &&
                (w_next < u8u16_pkg::NONCHAR)) begin
              push_n          = 2'd1;
              unit0.code_unit = w_next[15:0];
            end
          end
          u8u16_pkg::SEQ_FOUR: begin
            if ((w_next >= u8u16_pkg::MIN_FOUR) && (w_next < u8u16_pkg::MAX_UNICODE)) begin
              push_n          = 2'd2;
              unit0.code_unit = {u8u16_pkg::HIGH_SURR_TAG, v_off[19:10]};
              unit1.code_unit = {u8u16_pkg::LOW_SURR_TAG, v_off[9:0]};
            end
          end
          default: begin
            push_n = 2'd0;
          end
        endcase
      end
    end else begin
      // Fresh byte; a pending sequence, if any, is dropped.
      pv_d  = '0;
      rem_d = 2'd0;
      len_d = u8u16_pkg::SEQ_NONE;
      if (ib_q[7] == 1'b0) begin
        push_n          = 2'd1;
        unit0.code_unit = {8'h00, ib_q};
      end else if (ib_q[7:5] == 3'b110) begin
        pv_d  = {16'h0000, ib_q[4:0]};
        rem_d = 2'd1;
        len_d = u8u16_pkg::SEQ_TWO;
      end else if (ib_q[7:4] == 4'b1110) begin
        pv_d  = {17'h00000, ib_q[3:0]};
        rem_d = 2'd2;
        len_d = u8u16_pkg::SEQ_THREE;
      end else if (ib_q[7:3] == 5'b11110) begin
        pv_d  = {18'h00000, ib_q[2:0]};
        rem_d = 2'd3;
        len_d = u8u16_pkg::SEQ_FOUR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      rem_q <= 2'd0;
      len_q <= u8u16_pkg::SEQ_NONE;
    end else if (fire) begin
      pv_q  <= pv_d;
      rem_q <= rem_d;
      len_q <= len_d;
    end
  end

  // Result queue: up to two beats in, one beat out per cycle while the output is not stalled.
  assign pop   = out_valid_o && !out_stall_i;
  assign cnt_d = cnt_q + ((u8u16_pkg::QAW+1)'(fire ? push_n : 2'd0))
                       - ((u8u16_pkg::QAW+1)'(pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (fire) begin
        wr_q <= wr_q + u8u16_pkg::QAW'(push_n);
      end
      if (pop) begin
        rd_q <= rd_q + u8u16_pkg::QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && (push_n != 2'd0)) begin
      q_mem[wr_q] <= unit0;
    end
    if (fire && (push_n == 2'd2)) begin
      q_mem[wr_q + u8u16_pkg::QAW'(1)] <= unit1;
    end
  end

  assign out_valid_o     = (cnt_q != '0);
  assign code_unit_o     = q_mem[rd_q].code_unit;
  assign end_of_string_o = q_mem[rd_q].end_of_string;

`ifndef SYNTHESIS
  // The queue never holds more beats than it has entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (u8u16_pkg::QAW+1)'(u8u16_pkg::QDEPTH))
    else $error("result queue overflow");

  // The end-of-string beat always carries a zero unit.
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_string_o) |-> (code_unit_o == 16'h0000))
    else $error("end-of-string beat with nonzero unit");

  // A high surrogate at the head always has its low half queued behind it.
  a_pair_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (code_unit_o[15:10] == u8u16_pkg::HIGH_SURR_TAG))
      |-> (cnt_q >= (u8u16_pkg::QAW+1)'(2)))
    else $error("high surrogate without its low half");

  // A zero byte leaves no sequence pending.
  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (ib_q == 8'h00)) |=> (rem_q == 2'd0))
    else $error("pending sequence survived a zero byte");
`endif

endmodule

### tb/sv/tb_utf8_to_utf16_stream_decoder.sv
`timescale 1ns / 100ps

module tb_utf8_to_utf16_stream_decoder;

  // A marker in the byte queue: the sender waits until every expected unit has come.
  localparam int DRAIN_MARK  = -1;
  localparam int PHASE_BYTES = 570;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 12;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i       = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [15:0] code_unit_o;
  logic        end_of_string_o;

  // Bytes waiting to be sent and code units waiting to come back.
  int                pending_bytes[$];
  u8u16_pkg::unit_t  expected_units[$];

  // Decoder state as the checker sees it.
  logic [20:0] part_value = '0;
  logic [1:0]  cont_left  = u8u16_pkg::SEQ_NONE;
  logic [1:0]  cont_total = u8u16_pkg::SEQ_NONE;

  int          send_idle_pct = 9;
  int          recv_idle_pct = 53;
  logic        byte_taken    = 1'b0;
  int          error_count   = 0;
  int          bytes_taken   = 0;
  int          units_seen    = 0;
  int          ends_seen     = 0;
  int          pairs_seen    = 0;
  int          cycle_count   = 0;

  utf8_to_utf16_stream_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_unit_o     (code_unit_o),
    .end_of_string_o (end_of_string_o)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic u8u16_pkg::unit_t make_unit(input logic [15:0] unit, input logic eos);
    u8u16_pkg::unit_t u;
    u.code_unit     = unit;
    u.end_of_string = eos;
    return u;
  endfunction

  // Checks a completed sequence and queues the units it yields.
  task automatic close_sequence();
    logic [20:0] w;
    logic [1:0]  len;
    logic [20:0] v;
    w          = part_value;
    len        = cont_total;
    part_value = '0;
    cont_left  = u8u16_pkg::SEQ_NONE;
    cont_total = u8u16_pkg::SEQ_NONE;
    case (len)
      u8u16_pkg::SEQ_TWO: begin
        if (w >= u8u16_pkg::MIN_TWO) expected_units.push_back(make_unit(w[15:0], 1'b0));
      end
      u8u16_pkg::SEQ_THREE: begin
        if (w >= u8u16_pkg::MIN_THREE &&
            (w < u8u16_pkg::SURR_LO || w >= u8u16_pkg::SURR_HI) &&
            w < u8u16_pkg::NONCHAR)
          expected_units.push_back(make_unit(w[15:0], 1'b0));
      end
      u8u16_pkg::SEQ_FOUR: begin
        if (w >= u8u16_pkg::MIN_FOUR && w < u8u16_pkg::MAX_UNICODE) begin
          v = w - u8u16_pkg::MIN_FOUR;
          expected_units.push_back(make_unit({u8u16_pkg::HIGH_SURR_TAG, v[19:10]}, 1'b0));
          expected_units.push_back(make_unit({u8u16_pkg::LOW_SURR_TAG, v[9:0]}, 1'b0));
        end
      end
      default: ;
    endcase
  endtask

  // Advances the decoder state by one byte and queues any resulting units.
  task automatic decode_byte(input logic [7:0] b);
    logic fresh;
    fresh = 1'b1;
    if (b == 8'h00) begin
      part_value = '0;
      cont_left  = u8u16_pkg::SEQ_NONE;
      cont_total = u8u16_pkg::SEQ_NONE;
      expected_units.push_back(make_unit(16'h0000, 1'b1));
      fresh = 1'b0;
    end else if (cont_left != u8u16_pkg::SEQ_NONE) begin
      if (b[7:6] == 2'b10) begin
        part_value = {part_value[14:0], b[5:0]};
        cont_left  = cont_left - 2'd1;
        if (cont_left == u8u16_pkg::SEQ_NONE) close_sequence();
        fresh = 1'b0;
      end else begin
        // A broken sequence is dropped and the byte starts over.
        part_value = '0;
        cont_left  = u8u16_pkg::SEQ_NONE;
        cont_total = u8u16_pkg::SEQ_NONE;
      end
    end
    if (fresh) begin
      if (b[7] == 1'b0) begin
        expected_units.push_back(make_unit({8'h00, b}, 1'b0));
      end else if (b[7:5] == 3'b110) begin
        part_value = {16'h0000, b[4:0]};
        cont_left  = u8u16_pkg::SEQ_TWO;
        cont_total = u8u16_pkg::SEQ_TWO;
      end else if (b[7:4] == 4'b1110) begin
        part_value = {17'h00000, b[3:0]};
        cont_left  = u8u16_pkg::SEQ_THREE;
        cont_total = u8u16_pkg::SEQ_THREE;
      end else if (b[7:3] == 5'b11110) begin
        part_value = {18'h00000, b[2:0]};
        cont_left  = u8u16_pkg::SEQ_FOUR;
        cont_total = u8u16_pkg::SEQ_FOUR;
      end
    end
  endtask

  // Encodes a code point in the given number of bytes, overlong or not.
  task automatic push_code_point(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: pending_bytes.push_back(int'({1'b0, cp[6:0]}));
      2: begin
        pending_bytes.push_back(int'({3'b110, cp[10:6]}));
        pending_bytes.push_back(int'({2'b10, cp[5:0]}));
      end
      3: begin
        pending_bytes.push_back(int'({4'b1110, cp[15:12]}));
        pending_bytes.push_back(int'({2'b10, cp[11:6]}));
        pending_bytes.push_back(int'({2'b10, cp[5:0]}));
      end
      default: begin
        pending_bytes.push_back(int'({5'b11110, cp[20:18]}));
        pending_bytes.push_back(int'({2'b10, cp[17:12]}));
        pending_bytes.push_back(int'({2'b10, cp[11:6]}));
        pending_bytes.push_back(int'({2'b10, cp[5:0]}));
      end
    endcase
  endtask

  // Mostly well-formed characters with random content, plus malformed input and noise.
  task automatic add_random_char();
    int          pick;
    int          nbytes;
    int          k;
    logic [20:0] cp;
    pick = $urandom_range(99);
    if (pick < 15) begin
      push_code_point(21'($urandom_range(127, 1)), 1);
    end else if (pick < 30) begin
      push_code_point(21'($urandom_range(32'h7FF, 32'h80)), 2);
    end else if (pick < 45) begin
      push_code_point(21'($urandom_range(32'hFFFF, 32'h800)), 3);
    end else if (pick < 62) begin
      push_code_point(21'($urandom_range(32'h10FFFF, 32'h10000)), 4);
    end else if (pick < 70) begin
      // Values right at the edges of the accepted ranges.
      case ($urandom_range(9))
        0: push_code_point(21'h00080, 2);
        1: push_code_point(21'h007FF, 2);
        2: push_code_point(21'h00800, 3);
        3: push_code_point(21'h0D7FF, 3);
        4: push_code_point(21'h0E000, 3);
        5: push_code_point(21'h0FFFD, 3);
        6: push_code_point(21'h0DFFF, 3);
        7: push_code_point(21'h10000, 4);
        8: push_code_point(21'h10FFFF, 4);
        default: push_code_point(21'h110000, 4);
      endcase
    end else if (pick < 76) begin
      // Overlong forms.
      nbytes = $urandom_range(4, 2);
      case (nbytes)
        2:       cp = 21'($urandom_range(32'h7F));
        3:       cp = 21'($urandom_range(32'h7FF));
        default: cp = 21'($urandom_range(32'hFFFF));
      endcase
      push_code_point(cp, nbytes);
    end else if (pick < 80) begin
      // Surrogates and the two noncharacters.
      if ($urandom_range(1)) cp = 21'($urandom_range(32'hDFFF, 32'hD800));
      else cp = 21'($urandom_range(32'hFFFF, 32'hFFFE));
      push_code_point(cp, 3);
    end else if (pick < 84) begin
      push_code_point(21'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
    end else if (pick < 90) begin
      // A lead byte cut short by whatever comes next.
      nbytes = $urandom_range(4, 2);
      case (nbytes)
        2:       pending_bytes.push_back(int'({3'b110, 5'($urandom)}));
        3:       pending_bytes.push_back(int'({4'b1110, 4'($urandom)}));
        default: pending_bytes.push_back(int'({5'b11110, 3'($urandom)}));
      endcase
      k = $urandom_range(nbytes - 2);
      repeat (k) pending_bytes.push_back(int'({2'b10, 6'($urandom)}));
    end else if (pick < 97) begin
      pending_bytes.push_back($urandom_range(255, 1));
    end else begin
      pending_bytes.push_back(0);
    end
  endtask

  // Sender: presents the next byte at the falling edge once the last one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (pending_bytes.size() > 0 && pending_bytes[0] == DRAIN_MARK) begin
        in_valid_i <= 1'b0;
        if (expected_units.size() == 0) void'(pending_bytes.pop_front());
      end else if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_byte_i  <= 8'(pending_bytes.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall on the output channel.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predicts on each taken byte and checks each delivered unit.
  always @(posedge clk_i) begin
    u8u16_pkg::unit_t want;
    if (rst_ni) begin
      byte_taken = in_valid_i && !in_stall_o;
      if (byte_taken) begin
        decode_byte(in_byte_i);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        units_seen++;
        if (end_of_string_o) ends_seen++;
        if (code_unit_o[15:10] == u8u16_pkg::HIGH_SURR_TAG) pairs_seen++;
        if (expected_units.size() == 0) begin
          $error("unexpected beat: code_unit %h end_of_string %b", code_unit_o,
                 end_of_string_o);
          error_count++;
        end else begin
          want = expected_units.pop_front();
          if (code_unit_o !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, code_unit_o);
            error_count++;
          end
          if (end_of_string_o !== want.end_of_string) begin
            $error("end_of_string: expected %b, got %b", want.end_of_string,
                   end_of_string_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_utf8_to_utf16_stream_decoder: errors");
      $finish;
    end
  end

  // Stimulus: a directed opening, then three random phases with different idling.
  initial begin
    int directed_bytes[$];
    int phase;
    directed_bytes = '{
      8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBE, 8'hED, 8'hA0, 8'h80,
      8'hE0, 8'h9F, 8'hBF, 8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h8F,
      8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hBF, 8'hFF, 8'hE2,
      8'h41, 8'hE2, 8'h00
    };
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_bytes[i]) pending_bytes.push_back(directed_bytes[i]);
        pending_bytes.push_back(DRAIN_MARK);
      end
      while (pending_bytes.size() < PHASE_BYTES / 2) add_random_char();
      if (phase == 1) pending_bytes.push_back(DRAIN_MARK);
      while (pending_bytes.size() < PHASE_BYTES) add_random_char();

      // Let the phase drain before the idling pattern changes.
      while (pending_bytes.size() != 0 || in_valid_i || expected_units.size() != 0)
        @(negedge clk_i);
      @(posedge clk_i);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d UTF-8 bytes in three idling phases; got %0d code units,", bytes_taken,
             units_seen);
    $display("including %0d surrogate pairs and %0d string ends.", pairs_seen, ends_seen);
    if (error_count == 0) begin
      $display("tb_utf8_to_utf16_stream_decoder: clean");
    end else begin
      $display("tb_utf8_to_utf16_stream_decoder: errors");
    end
    $finish;
  end

endmodule
